// ----- rtl/core/pmdf_pkg.sv -----
// shared types, constants and register codes for the point motion delta filter
package pmdf_pkg;

  localparam int unsigned MAX_POINTS_DEF = 4096;
  localparam int unsigned IDX_W = 12;
  localparam int unsigned FRAME_W = 16;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned RATIO_W = 31;
  localparam int unsigned IN_DATA_W = 256;
  localparam int unsigned OUT_DATA_W = 240;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_POS_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 2'd2;

  localparam logic [RATIO_W-1:0] POS_THR_RST = 31'd66;
  localparam logic [RATIO_W-1:0] RATIO_THR_RST = 31'd66;
  localparam logic [COORD_W-1:0] TIME_STEP_RST = 32'd42950;
  localparam logic [RATIO_W-1:0] ONE_Q16 = 31'd65536;

  typedef struct packed {
    logic first;
    logic inrange;
    logic [IDX_W-1:0] idx;
    logic [FRAME_W-1:0] frame;
    logic [2:0][COORD_W-1:0] pos;
    logic [2:0][COORD_W-1:0] vel;
    logic [RATIO_W-1:0] ratio;
  } item_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [RATIO_W-1:0] ratio;
    logic [2:0][COORD_W-1:0] vel;
    logic [2:0][COORD_W-1:0] pos;
  } ent_t;

  typedef struct packed {
    logic [RATIO_W-1:0] pos_thr;
    logic [RATIO_W-1:0] ratio_thr;
    logic [COORD_W-1:0] time_step;
    logic [2*RATIO_W-1:0] pos_thr_sq;
  } cfg_t;

endpackage

// ----- rtl/core/pmdf_front.sv -----
// input side: unpacks, tags first-frame and range, queues items for the back end
module pmdf_front #(
  parameter int unsigned MAX_POINTS = pmdf_pkg::MAX_POINTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [pmdf_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic s_axis_tlast,
  input  logic pop,
  output logic q_valid,
  output pmdf_pkg::item_t q_item
);
  import pmdf_pkg::*;

  localparam int unsigned QD = 4;

  item_t buffer [QD];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic have_reference;
  logic push;
  item_t in_item;

  assign s_axis_tready = (count != 3'(QD));
  assign push = s_axis_tvalid && s_axis_tready;
  assign q_valid = (count != 3'd0);
  assign q_item = buffer[rd_ptr];

  always_comb begin
    in_item.first = !have_reference;
    in_item.inrange = (32'(s_axis_tdata[11:0]) < 32'(MAX_POINTS));
    in_item.idx = s_axis_tdata[11:0];
    in_item.frame = s_axis_tdata[27:12];
    in_item.pos[0] = s_axis_tdata[59:28];
    in_item.pos[1] = s_axis_tdata[91:60];
    in_item.pos[2] = s_axis_tdata[123:92];
    in_item.vel[0] = s_axis_tdata[155:124];
    in_item.vel[1] = s_axis_tdata[187:156];
    in_item.vel[2] = s_axis_tdata[219:188];
    in_item.ratio = s_axis_tdata[250:220];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buffer[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
      have_reference <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 2'd1;
        if (s_axis_tlast) begin
          have_reference <= 1'b1;
        end
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + 3'(push) - 3'(pop);
    end
  end
endmodule

// ----- rtl/core/pmdf_back.sv -----
// back end: reference store, dead-reckoning error pipeline, refresh decision, output register
module pmdf_back #(
  parameter int unsigned MAX_POINTS = pmdf_pkg::MAX_POINTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  pmdf_pkg::cfg_t cfg,
  input  logic q_valid,
  input  pmdf_pkg::item_t q_item,
  output logic pop,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [pmdf_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import pmdf_pkg::*;

  localparam int unsigned DEPTH = (MAX_POINTS < 4096) ? MAX_POINTS : 4096;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NS = 6;

  ent_t mem [DEPTH];
  ent_t rd1;

  logic adv;
  logic hazard;
  logic [NS:1] v;
  item_t it [NS:1];

  // stage 2
  logic [47:0] t2;
  logic rflag [NS:2];
  ent_t ref2;
  // stage 3
  logic [2:0][63:0] lo3;
  logic [2:0][47:0] hi3;
  logic [2:0] neg3;
  logic [2:0][COORD_W-1:0] rp3;
  // stage 4
  logic signed [2:0][50:0] e4;
  // stage 5
  logic [2:0][RATIO_W-1:0] a5;
  logic sat5;
  // stage 6
  logic [2:0][2*RATIO_W-1:0] sq6;
  logic sat6;

  logic [FRAME_W-1:0] elapsed;
  logic [RATIO_W:0] rdiff;
  logic leaves_one;
  logic ratio_hit;
  logic [2:0][COORD_W-1:0] mag2;
  logic [2:0] neg2;
  logic signed [2:0][50:0] e_next;
  logic [2:0][50:0] abs4;
  logic [2:0] sat4;
  logic [63:0] sum6;
  logic emit;

  assign adv = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    hazard = 1'b0;
    for (int s = 1; s <= NS; s++) begin
      if (v[s] && it[s].inrange && q_item.inrange && it[s].idx == q_item.idx) begin
        hazard = 1'b1;
      end
    end
  end

  assign pop = q_valid && adv && !hazard;

  // stage 1 compare helpers
  always_comb begin
    elapsed = it[1].frame - rd1.frame;
    if (it[1].ratio >= rd1.ratio) begin
      rdiff = {1'b0, it[1].ratio} - {1'b0, rd1.ratio};
    end else begin
      rdiff = {1'b0, rd1.ratio} - {1'b0, it[1].ratio};
    end
    leaves_one = (rd1.ratio == ONE_Q16) && (it[1].ratio != ONE_Q16);
    ratio_hit = (rdiff > {1'b0, cfg.ratio_thr}) || leaves_one;
  end

  // stage 2 magnitudes
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      neg2[a] = ref2.vel[a][COORD_W-1];
      mag2[a] = neg2[a] ? (~ref2.vel[a] + 32'd1) : ref2.vel[a];
    end
  end

  // stage 3 rounded drift and error
  always_comb begin
    logic [48:0] m;
    for (int a = 0; a < 3; a++) begin
      m = {1'b0, hi3[a]} + 49'(lo3[a][63:32]) + 49'(lo3[a][31]);
      e_next[a] = 51'(signed'(it[3].pos[a])) - 51'(signed'(rp3[a]))
                  - (neg3[a] ? -signed'({2'b00, m}) : signed'({2'b00, m}));
    end
  end

  // stage 4 magnitude and saturation
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      abs4[a] = e4[a][50] ? 51'(-e4[a]) : 51'(e4[a]);
      sat4[a] = (abs4[a] >= 51'h80000000);
    end
  end

  always_comb begin
    sum6 = 64'(sq6[0]) + 64'(sq6[1]) + 64'(sq6[2]);
    emit = it[6].inrange &&
           (it[6].first || sat6 || rflag[6] || (sum6 > 64'(cfg.pos_thr_sq)));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd1 <= mem[q_item.idx[AW-1:0]];
      it[1] <= q_item;
      for (int s = 2; s <= NS; s++) begin
        it[s] <= it[s-1];
      end
      ref2 <= rd1;
      t2 <= 48'(cfg.time_step) * 48'(elapsed);
      rflag[2] <= ratio_hit;
      for (int s = 3; s <= NS; s++) begin
        rflag[s] <= rflag[s-1];
      end
      for (int a = 0; a < 3; a++) begin
        lo3[a] <= 64'(mag2[a]) * 64'(t2[31:0]);
        hi3[a] <= 48'(mag2[a]) * 48'(t2[47:32]);
        e4[a] <= e_next[a];
        a5[a] <= abs4[a][RATIO_W-1:0];
        sq6[a] <= 62'(a5[a]) * 62'(a5[a]);
      end
      neg3 <= neg2;
      rp3 <= ref2.pos;
      sat5 <= |sat4;
      sat6 <= sat5;
      if (v[NS] && emit) begin
        mem[it[NS].idx[AW-1:0]] <= '{frame: it[NS].frame, ratio: it[NS].ratio,
                                     vel: it[NS].vel, pos: it[NS].pos};
        m_axis_tdata <= {5'd0, it[NS].ratio, it[NS].vel[2], it[NS].vel[1], it[NS].vel[0],
                         it[NS].pos[2], it[NS].pos[1], it[NS].pos[0], it[NS].idx};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      v <= {v[NS-1:1], pop};
      m_axis_tvalid <= v[NS] && emit;
    end
  end
endmodule

// ----- rtl/core/point_motion_delta_filter_core.sv -----
// Point motion delta filter: one particle sample per input transfer; an in-range sample is
// passed on and becomes the new reference when it belongs to the first frame or when the
// dead-reckoned position error, the ratio change or a ratio leaving 1.0 calls for it.
// Throughput is one transfer per cycle while the input queue has room. An item waits while
// an earlier sample of the same particle is still inside the six-stage error pipeline (read
// to write-back of the reference store) and while the output is held by the receiver. The
// user must see that registers are written only while idle; the block does not enforce it.
module point_motion_delta_filter_core #(
  parameter int unsigned MAX_POINTS = pmdf_pkg::MAX_POINTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // point_index, frame, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, volume_ratio
  input  logic [pmdf_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic s_axis_tlast,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // out_point_index, out_pos_x/y/z, out_vel_x/y/z, out_volume_ratio
  output logic [pmdf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [pmdf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pmdf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pmdf_pkg::*;

  cfg_t cfg;
  logic q_valid;
  item_t q_item;
  logic pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    cfg.pos_thr_sq <= 62'(cfg.pos_thr) * 62'(cfg.pos_thr);
    if (rst) begin
      cfg.pos_thr <= POS_THR_RST;
      cfg.ratio_thr <= RATIO_THR_RST;
      cfg.time_step <= TIME_STEP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_POS_THR: cfg.pos_thr <= cfg_data[RATIO_W-1:0];
        REG_RATIO_THR: cfg.ratio_thr <= cfg_data[RATIO_W-1:0];
        REG_TIME_STEP: cfg.time_step <= cfg_data;
        default: ;
      endcase
    end
  end

  pmdf_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .pop(pop), .q_valid(q_valid), .q_item(q_item)
  );

  pmdf_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .q_valid(q_valid), .q_item(q_item), .pop(pop),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );
endmodule

// ----- rtl/core/pmdf_checker.sv -----
// port-level checks for the point motion delta filter
module pmdf_checker #(
  parameter int unsigned MAX_POINTS = pmdf_pkg::MAX_POINTS_DEF
) (
  input logic clk,
  input logic rst,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [pmdf_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output transfer dropped while stalled");

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_reset_ready: assert property (@(posedge clk) rst |=> s_axis_tready)
    else $error("input not ready after reset");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[239:235] == 5'd0)
    else $error("output padding not zero");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> 32'(m_axis_tdata[11:0]) < 32'(MAX_POINTS))
    else $error("out-of-range index emitted");
endmodule

bind point_motion_delta_filter_core pmdf_checker #(.MAX_POINTS(MAX_POINTS)) u_pmdf_checker (.*);

// ----- sim/pmdf_checker.sv -----
// scoreboard for the point motion delta filter: predicts refreshed samples and compares them
`timescale 1ns / 1ps

module pmdf_scoreboard (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  input  logic s_axis_tready,
  input  logic [pmdf_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic s_axis_tlast,
  input  logic m_axis_tvalid,
  input  logic m_axis_tready,
  input  logic [pmdf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  logic [pmdf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pmdf_pkg::CFG_DATA_W-1:0] cfg_data,
  output int errors,
  output int pending
);
  import pmdf_pkg::*;

  logic [RATIO_W-1:0] pos_thr = POS_THR_RST;
  logic [RATIO_W-1:0] ratio_thr = RATIO_THR_RST;
  logic [COORD_W-1:0] step_len = TIME_STEP_RST;
  logic have_ref = 1'b0;

  logic [2:0][COORD_W-1:0] ref_pos [MAX_POINTS_DEF];
  logic [2:0][COORD_W-1:0] ref_vel [MAX_POINTS_DEF];
  logic [RATIO_W-1:0] ref_ratio [MAX_POINTS_DEF];
  logic [FRAME_W-1:0] ref_frame [MAX_POINTS_DEF];

  logic [OUT_DATA_W-1:0] refreshed_q [$];

  initial errors = 0;
  assign pending = refreshed_q.size();

  function automatic longint drift_of(logic [31:0] v, longint unsigned t);
    longint unsigned m, lo, mag;
    m = v[31] ? (64'd0 - {{32{1'b1}}, v}) : {32'd0, v};
    lo = m * t[31:0];
    mag = m * (t >> 32) + (lo >> 32) + lo[31];
    return v[31] ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic refresh_needed(logic [11:0] idx, logic [15:0] frame,
                                          logic [2:0][31:0] p, logic [30:0] ratio);
    logic [15:0] elapsed;
    longint unsigned t, sq, a;
    longint e, rd;
    logic sat;
    elapsed = frame - ref_frame[idx];
    t = longint'(step_len) * longint'(elapsed);
    sq = 0;
    sat = 1'b0;
    for (int k = 0; k < 3; k++) begin
      e = longint'($signed(p[k])) - longint'($signed(ref_pos[idx][k]))
          - drift_of(ref_vel[idx][k], t);
      a = e < 0 ? -e : e;
      if (a >= 64'h8000_0000) sat = 1'b1;
      else sq += a * a;
    end
    rd = longint'(ratio) - longint'(ref_ratio[idx]);
    if (rd < 0) rd = -rd;
    return sat || sq > longint'(pos_thr) * longint'(pos_thr) || rd > longint'(ratio_thr)
           || (ref_ratio[idx] == ONE_Q16 && ratio != ONE_Q16);
  endfunction

  always @(posedge clk) begin
    logic [OUT_DATA_W-1:0] exp_d;
    logic [11:0] idx;
    logic [2:0][31:0] p, v;
    logic [30:0] ratio;
    logic [15:0] frame;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (refreshed_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected output transfer %h", m_axis_tdata);
        end else begin
          exp_d = refreshed_q.pop_front();
          if (exp_d != m_axis_tdata) begin
            errors++;
            if (errors <= 10) begin
              $display("output mismatch");
              $display("  index exp %h got %h", exp_d[11:0], m_axis_tdata[11:0]);
              for (int k = 0; k < 6; k++)
                $display("  coord %0d exp %h got %h", k, exp_d[12+32*k +: 32],
                         m_axis_tdata[12+32*k +: 32]);
              $display("  ratio exp %h got %h", exp_d[204 +: 31], m_axis_tdata[204 +: 31]);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_POS_THR: pos_thr = cfg_data[30:0];
          REG_RATIO_THR: ratio_thr = cfg_data[30:0];
          REG_TIME_STEP: step_len = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        idx = s_axis_tdata[11:0];
        frame = s_axis_tdata[27:12];
        p = s_axis_tdata[123:28];
        v = s_axis_tdata[219:124];
        ratio = s_axis_tdata[250:220];
        if (!have_ref || refresh_needed(idx, frame, p, ratio)) begin
          ref_pos[idx] = p;
          ref_vel[idx] = v;
          ref_ratio[idx] = ratio;
          ref_frame[idx] = frame;
          refreshed_q.insert(refreshed_q.size(), {5'd0, ratio, v, p, idx});
        end
        if (s_axis_tlast) have_ref = 1'b1;
      end
    end
  end

endmodule

// ----- sim/testbench.sv -----
// stimulus, clocking and verdict for the point motion delta filter core
`timescale 1ns / 1ps

module testbench;
  import pmdf_pkg::*;

  typedef struct packed {
    logic [11:0] idx;
    logic [15:0] frame;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [30:0] ratio;
    logic last;
  } sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int errors, pending;
  int cycles = 0;
  bit hold_req = 0;
  bit burst = 0;

  logic [2:0][31:0] last_pos [16];
  logic [30:0] last_ratio [16];
  logic [15:0] cur_frame;

  always #2 clk = ~clk;

  point_motion_delta_filter_core DUT (.*);

  pmdf_scoreboard checker_i (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int r;
    @(negedge rst);
    forever begin
      r = $urandom_range(0, 99);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (500) @(posedge clk);
        hold_req = 0;
      end else if (!burst && r < 20) begin
        m_axis_tready <= 1'b0;
        repeat (r < 2 ? $urandom_range(20, 60) : $urandom_range(1, 3)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic logic [11:0] slot_index(int k);
    return k < 8 ? 12'(k) : 12'(4080 + k);
  endfunction

  task automatic send_sample(sample_t s);
    int r;
    s_axis_tdata <= {5'd0, s.ratio, s.vel, s.pos, s.frame, s.idx};
    s_axis_tlast <= s.last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    r = $urandom_range(0, 99);
    if (!burst && r < 25) begin
      s_axis_tvalid <= 1'b0;
      repeat (r < 2 ? $urandom_range(20, 60) : $urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] ri, logic [31:0] val);
    cfg_index <= ri;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [31:0] jitter(logic [31:0] x, int span);
    return x + 32'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic send_slot(int k, sample_t s);
    s.idx = slot_index(k);
    s.frame = cur_frame;
    last_pos[k] = s.pos;
    last_ratio[k] = s.ratio;
    send_sample(s);
  endtask

  task automatic random_run(int count);
    sample_t s;
    int k, mode, left;
    left = $urandom_range(1, 20);
    for (int n = 0; n < count; n++) begin
      if (--left == 0) begin
        left = $urandom_range(1, 20);
        cur_frame += ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 3));
        burst = ($urandom_range(0, 5) == 0);
      end
      k = $urandom_range(0, 15);
      mode = $urandom_range(0, 99);
      s.last = 1'($urandom);
      if (mode < 55) begin
        for (int c = 0; c < 3; c++) begin
          s.pos[c] = jitter(last_pos[k][c], 120);
          s.vel[c] = $urandom_range(0, 3) == 0 ? $urandom : jitter(32'd0, 8);
        end
        s.ratio = $urandom_range(0, 3) == 0 ? ONE_Q16
                : 31'(jitter({1'b0, last_ratio[k]}, 120));
      end else if (mode < 70) begin
        s.pos = last_pos[k];
        s.vel = '0;
        s.ratio = $urandom_range(0, 1) ? ONE_Q16 : last_ratio[k];
      end else begin
        for (int c = 0; c < 3; c++) begin
          s.pos[c] = $urandom;
          s.vel[c] = $urandom;
        end
        s.ratio = 31'($urandom);
      end
      send_slot(k, s);
    end
    burst = 0;
  endtask

  initial begin
    sample_t s;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_reg(REG_POS_THR, 32'(POS_THR_RST));
    write_reg(REG_RATIO_THR, 32'(RATIO_THR_RST));
    write_reg(REG_TIME_STEP, TIME_STEP_RST);

    // first frame: every slot gets a reference, field extremes included
    cur_frame = 16'hFFFE;
    for (int k = 0; k < 16; k++) begin
      s.last = (k == 15);
      s.pos = '0;
      s.vel = '0;
      s.ratio = ONE_Q16;
      case (k)
        2: s.pos = {3{32'h8000_0000}};
        3: s.pos = {3{32'h7FFF_FFFF}};
        4: s.vel = {3{32'h8000_0000}};
        5: s.vel = {3{32'h7FFF_FFFF}};
        6: s.ratio = 31'd0;
        7: s.ratio = 31'h7FFF_FFFF;
        default: begin
          s.pos = {$urandom, $urandom, $urandom};
          s.vel = {$urandom, $urandom, $urandom};
          s.ratio = 31'($urandom);
        end
      endcase
      if (k == 1) s.ratio = ONE_Q16;
      send_slot(k, s);
    end

    // second frame across the frame-number wrap: leaving 1.0, saturation, big drift
    cur_frame = 16'h0001;
    s.last = 1'b1;
    s.vel = '0;
    s.pos = '0;
    s.ratio = ONE_Q16;
    send_slot(0, s);
    s.pos = last_pos[1];
    s.ratio = 31'd65537;
    send_slot(1, s);
    s.pos = {3{32'h7FFF_FFFF}};
    s.ratio = ONE_Q16;
    send_slot(2, s);
    s.pos = '0;
    send_slot(4, s);
    send_slot(5, s);
    s.ratio = 31'h7FFF_FFFF;
    send_slot(6, s);
    s.ratio = 31'd0;
    send_slot(7, s);
    drain();

    random_run(270);
    drain();
    write_reg(REG_POS_THR, 32'd0);
    write_reg(REG_RATIO_THR, 32'd0);
    write_reg(REG_TIME_STEP, 32'd0);
    random_run(270);
    drain();
    write_reg(REG_POS_THR, 32'h7FFF_FFFF);
    write_reg(REG_RATIO_THR, 32'h7FFF_FFFF);
    write_reg(REG_TIME_STEP, 32'hFFFF_FFFF);
    hold_req = 1;
    random_run(270);
    drain();
    write_reg(REG_POS_THR, 32'd100);
    write_reg(REG_RATIO_THR, 32'd1000);
    write_reg(REG_TIME_STEP, $urandom);
    random_run(270);
    drain();
    write_reg(REG_POS_THR, $urandom_range(0, 400));
    write_reg(REG_RATIO_THR, $urandom_range(0, 400));
    write_reg(REG_TIME_STEP, $urandom_range(0, 1 << 20));
    random_run(270);
    drain();
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
